FILE: sv/qau_pkg.sv
`timescale 1ns / 1ps

package qau_pkg;

    localparam int COMP_W = 16;
    localparam int FRAC_W = COMP_W - 4;
    localparam int PROD_W = 2 * COMP_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - FRAC_W;
    localparam int LIN_W  = COMP_W + 1;
    localparam int TERMS  = 4;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SUB   = 2'd1,
        OP_MUL   = 2'd2,
        OP_SCALE = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [COMP_W-1:0] a_x;
        logic signed [COMP_W-1:0] a_y;
        logic signed [COMP_W-1:0] a_z;
        logic signed [COMP_W-1:0] a_w;
        logic signed [COMP_W-1:0] b_x;
        logic signed [COMP_W-1:0] b_y;
        logic signed [COMP_W-1:0] b_z;
        logic signed [COMP_W-1:0] b_w;
        logic signed [COMP_W-1:0] scale_factor;
    } in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] res_x;
        logic signed [COMP_W-1:0] res_y;
        logic signed [COMP_W-1:0] res_z;
        logic signed [COMP_W-1:0] res_w;
        logic                     saturated;
    } out_t;

    // per-stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } qau_en_t;

    // component order: 0 x, 1 y, 2 z, 3 w
    // Hamilton term k of every component uses a[A_IDX[k]] * b[B_IDX[c][k]]
    localparam logic [TERMS-1:0][1:0] A_IDX = {2'd2, 2'd1, 2'd0, 2'd3};

    localparam logic [3:0][TERMS-1:0][1:0] B_IDX = {
        2'd2, 2'd1, 2'd0, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd3, 2'd2, 2'd1,
        2'd1, 2'd2, 2'd3, 2'd0
    };

    localparam logic [3:0][TERMS-1:0] NEG = {4'b1110, 4'b0100, 4'b0010, 4'b1000};

endpackage

FILE: sv/qau_lane.sv
`timescale 1ns / 1ps

module qau_lane (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  qau_pkg::qau_en_t                           en,
    input  qau_pkg::opcode_t                           op,
    input  logic [qau_pkg::TERMS-1:0][qau_pkg::COMP_W-1:0] ma,
    input  logic [qau_pkg::TERMS-1:0][qau_pkg::COMP_W-1:0] mb,
    input  logic [qau_pkg::TERMS-1:0]                  neg,
    input  logic signed [qau_pkg::COMP_W-1:0]          lin_a,
    input  logic signed [qau_pkg::COMP_W-1:0]          lin_b,
    output logic signed [qau_pkg::COMP_W-1:0]          res,
    output logic                                       sat
);

    localparam int W = qau_pkg::COMP_W;
    localparam int T = qau_pkg::TERMS;
    localparam logic signed [qau_pkg::RND_W-1:0] SAT_HI =
        {{(qau_pkg::RND_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [qau_pkg::RND_W-1:0] SAT_LO =
        {{(qau_pkg::RND_W-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [qau_pkg::SUM_W-1:0] HALF =
        qau_pkg::SUM_W'(1) << (qau_pkg::FRAC_W - 1);

    // stage 1: products, add/sub
    logic signed [qau_pkg::PROD_W-1:0] prod_reg [T];
    logic signed [qau_pkg::PROD_W-1:0] prod_next [T];
    logic [T-1:0]                      neg1_reg;
    logic signed [qau_pkg::LIN_W-1:0]  lin1_reg;
    logic signed [qau_pkg::LIN_W-1:0]  lin1_next;
    qau_pkg::opcode_t                  op1_reg;

    // stage 2: exact sum
    logic signed [qau_pkg::SUM_W-1:0]  sum2_reg;
    logic signed [qau_pkg::SUM_W-1:0]  sum2_next;
    logic signed [qau_pkg::LIN_W-1:0]  lin2_reg;
    qau_pkg::opcode_t                  op2_reg;

    // stage 3: rounded sum, or add/sub result, before clipping
    logic signed [qau_pkg::RND_W-1:0]  rnd3_reg;
    logic signed [qau_pkg::RND_W-1:0]  rnd3_next;
    logic signed [qau_pkg::SUM_W-1:0]  rnd_sum;

    // stage 4: output
    logic signed [W-1:0]               res_reg;
    logic signed [W-1:0]               res_next;
    logic                              sat_reg;
    logic                              sat_next;

    logic signed [qau_pkg::SUM_W-1:0]  term [T];

    always_comb
    begin
        for (int k = 0; k < T; k++)
        begin
            prod_next[k] = qau_pkg::PROD_W'($signed(ma[k])) *
                           qau_pkg::PROD_W'($signed(mb[k]));
        end
        if (op == qau_pkg::OP_SUB)
        begin
            lin1_next = {lin_a[W-1], lin_a} - {lin_b[W-1], lin_b};
        end
        else
        begin
            lin1_next = {lin_a[W-1], lin_a} + {lin_b[W-1], lin_b};
        end
    end

    always_comb
    begin
        for (int k = 0; k < T; k++)
        begin
            term[k] = {{2{prod_reg[k][qau_pkg::PROD_W-1]}}, prod_reg[k]};
            if (neg1_reg[k])
            begin
                term[k] = -term[k];
            end
        end
        sum2_next = (term[0] + term[1]) + (term[2] + term[3]);
    end

    always_comb
    begin
        rnd_sum = sum2_reg + HALF;
        case (op2_reg)
            qau_pkg::OP_ADD, qau_pkg::OP_SUB:
            begin
                rnd3_next = {{(qau_pkg::RND_W-qau_pkg::LIN_W){lin2_reg[qau_pkg::LIN_W-1]}},
                             lin2_reg};
            end
            default:
            begin
                rnd3_next = rnd_sum[qau_pkg::SUM_W-1:qau_pkg::FRAC_W];
            end
        endcase
    end

    always_comb
    begin
        if (rnd3_reg > SAT_HI)
        begin
            res_next = SAT_HI[W-1:0];
            sat_next = 1'b1;
        end
        else if (rnd3_reg < SAT_LO)
        begin
            res_next = SAT_LO[W-1:0];
            sat_next = 1'b1;
        end
        else
        begin
            res_next = rnd3_reg[W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            for (int k = 0; k < T; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            neg1_reg <= neg;
            lin1_reg <= lin1_next;
        end
        if (en.s2)
        begin
            sum2_reg <= sum2_next;
            lin2_reg <= lin1_reg;
        end
        if (en.s3)
        begin
            rnd3_reg <= rnd3_next;
        end
        if (en.s4)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= qau_pkg::OP_ADD;
            op2_reg <= qau_pkg::OP_ADD;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                op1_reg <= op;
            end
            if (en.s2)
            begin
                op2_reg <= op1_reg;
            end
            if (en.s4)
            begin
                sat_reg <= sat_next;
            end
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

FILE: sv/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps

// channel  valid      stall      payload    dir
// src      src_valid  src_stall  src_data   in   (qau_pkg::in_t)
// dst      dst_valid  dst_stall  dst_data   out  (qau_pkg::out_t)
//
// Four-stage pipeline: multiply (or add/sub), four-term sum, round, saturate.
// One transfer per cycle sustained while dst is not stalled.
// Bubbles are squeezed out; src_stall rises only when all four stages hold data
// and dst is stalled.
// rst_n clears the stage valid bits asynchronously.

module quaternion_arithmetic_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  qau_pkg::in_t   src_data,
    output logic           dst_valid,
    input  logic           dst_stall,
    output qau_pkg::out_t  dst_data
);

    localparam int W = qau_pkg::COMP_W;
    localparam int T = qau_pkg::TERMS;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    qau_pkg::qau_en_t en;

    logic [3:0][W-1:0]          av;
    logic [3:0][W-1:0]          bv;
    logic [3:0][T-1:0][W-1:0]   ma;
    logic [3:0][T-1:0][W-1:0]   mb;
    logic [3:0][T-1:0]          neg;
    logic [3:0][W-1:0]          res;
    logic [3:0]                 sat;

    assign rdy4 = !v4_reg || !dst_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;
    assign en.s4 = rdy4;

    assign src_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= src_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign av = {src_data.a_w, src_data.a_z, src_data.a_y, src_data.a_x};
    assign bv = {src_data.b_w, src_data.b_z, src_data.b_y, src_data.b_x};

    // operand routing; scale uses term 0 only
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < T; k++)
            begin
                ma[c][k]  = av[qau_pkg::A_IDX[k]];
                mb[c][k]  = bv[qau_pkg::B_IDX[c][k]];
                neg[c][k] = qau_pkg::NEG[c][k];
                if (src_data.opcode == qau_pkg::OP_SCALE)
                begin
                    neg[c][k] = 1'b0;
                    if (k == 0)
                    begin
                        ma[c][k] = av[c];
                        mb[c][k] = src_data.scale_factor;
                    end
                    else
                    begin
                        mb[c][k] = '0;
                    end
                end
            end
        end
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_lane
        qau_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .op    (src_data.opcode),
            .ma    (ma[c]),
            .mb    (mb[c]),
            .neg   (neg[c]),
            .lin_a (av[c]),
            .lin_b (bv[c]),
            .res   (res[c]),
            .sat   (sat[c])
        );
    end

    assign dst_valid          = v4_reg;
    assign dst_data.res_x     = res[0];
    assign dst_data.res_y     = res[1];
    assign dst_data.res_z     = res[2];
    assign dst_data.res_w     = res[3];
    assign dst_data.saturated = |sat;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && dst_stall))
        else $error("src stalled with a free stage");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (src_valid && !src_stall) |=> v1_reg)
        else $error("accepted transfer lost at stage 1");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !(v4_reg && dst_stall)) |=> dst_valid)
        else $error("stage 3 item did not reach output");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_data.saturated) |->
        (dst_data.res_x == {1'b0, {(W-1){1'b1}}} || dst_data.res_x == {1'b1, {(W-1){1'b0}}} ||
         dst_data.res_y == {1'b0, {(W-1){1'b1}}} || dst_data.res_y == {1'b1, {(W-1){1'b0}}} ||
         dst_data.res_z == {1'b0, {(W-1){1'b1}}} || dst_data.res_z == {1'b1, {(W-1){1'b0}}} ||
         dst_data.res_w == {1'b0, {(W-1){1'b1}}} || dst_data.res_w == {1'b1, {(W-1){1'b0}}}))
        else $error("saturated flag without a clipped component");

endmodule
